// ----- rtl/wcq_pkg.sv -----
// Shared types, codes and widths of the wavelet coefficient quantizer
package wcq_pkg;

    // fixed field widths
    localparam int PEAK_W    = 32;
    localparam int MODE_W    = 2;
    localparam int PLANES_W  = 5;
    localparam int DEPTH_W   = 4;
    localparam int SHIFT_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // product of two register-wide operands, and a quotient shifted by up to 30
    localparam int PROD_W    = 2 * PEAK_W;
    localparam int MAX_SHIFT = 30;
    localparam int RES_W     = PEAK_W + MAX_SHIFT;

    // one quotient bit per divider step
    localparam int DIV_STEPS = PEAK_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [PEAK_W-1:0]   PEAK_MAX     = {PEAK_W{1'b1}};
    localparam logic [PLANES_W-1:0] PLANES_RESET = 5'd7;

    // item commands
    localparam logic CMD_QUANT   = 1'b0;
    localparam logic CMD_DEQUANT = 1'b1;

    // scaling modes
    localparam logic [MODE_W-1:0] MODE_LINF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_L1   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_L2   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALING_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PLANES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_VALUE   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    // divider commands
    typedef struct packed {
        logic init;
        logic step;
    } div_cmd_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     load;
        logic     prep;
        logic     mul;
        div_cmd_t div;
        logic     finish;
    } dp_cmd_t;

endpackage

// ----- rtl/wcq_div.sv -----
// Restoring divider, one quotient bit per step, for quotients that fit the register width
module wcq_div
    import wcq_pkg::*;
(
    input  logic              clk,
    input  div_cmd_t          cmd,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PEAK_W-1:0] divisor,
    output logic [PEAK_W-1:0] quotient
);

    logic [PEAK_W-1:0] rem_reg;
    logic [PEAK_W-1:0] rem_next;
    logic [PEAK_W-1:0] quo_reg;
    logic [PEAK_W-1:0] quo_next;
    logic [PEAK_W:0]   trial;
    logic [PEAK_W+1:0] diff;
    logic              fits;

    // shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[PEAK_W-1]};
        diff     = {1'b0, trial} - {2'b00, divisor};
        fits     = ~diff[PEAK_W+1];
        rem_next = fits ? diff[PEAK_W-1:0] : trial[PEAK_W-1:0];
        quo_next = {quo_reg[PEAK_W-2:0], fits};
    end

    // upper half seeds the remainder, lower half is shifted through
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            rem_reg <= dividend[PROD_W-1:PEAK_W];
            quo_reg <= dividend[PEAK_W-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

// ----- rtl/wcq_datapath.sv -----
// Datapath: configuration, scaling, multiplier, divider, saturation and result register
module wcq_datapath
    import wcq_pkg::*;
#(
    parameter int MAX_DEPTH   = 15,
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [PEAK_W-1:0]             cfg_data,
    input  logic                          command,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic [DEPTH_W-1:0]            depth,
    output logic signed [VALUE_WIDTH-1:0] result,
    output logic [PEAK_W-1:0]             peak_seen,
    output logic [STATUS_W-1:0]           status
);

    localparam int CW = (VALUE_WIDTH > PEAK_W) ? VALUE_WIDTH : PEAK_W;
    localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(64'd1 << FRAC_BITS);

    // configuration registers
    logic [MODE_W-1:0]   mode_reg;
    logic [PLANES_W-1:0] planes_reg;
    logic [PEAK_W-1:0]   peak_reg;
    logic [PEAK_W-1:0]   full;

    // captured item
    logic                   cmd_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [SHIFT_W-1:0]     sh_reg;

    // prepared operands
    logic [PEAK_W-1:0] op_a_reg;
    logic [PEAK_W-1:0] op_b_reg;
    logic [PEAK_W-1:0] div_reg;
    logic              over_reg;
    logic              big_reg;
    logic              clamp_reg;
    logic [PROD_W-1:0] product_reg;
    logic [PEAK_W-1:0] run_peak_reg;
    logic [PEAK_W-1:0] run_peak_next;

    // result register
    logic [VALUE_WIDTH-1:0] result_reg;
    logic [VALUE_WIDTH-1:0] result_next;
    logic [PEAK_W-1:0]      peak_seen_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;

    // accept side
    logic [VALUE_WIDTH-1:0] value_u;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [DEPTH_W-1:0]     depth_sat;
    logic [SHIFT_W-1:0]     sh_in;

    // prep side
    logic [VALUE_WIDTH-1:0] s;
    logic [CW-1:0]          s_cw;
    logic [CW-1:0]          peak_cw;
    logic [CW-1:0]          d_cw;
    logic [CW-1:0]          mag_cw;
    logic                   over;
    logic                   big;
    logic                   clamp;
    logic [PEAK_W-1:0]      s_sat;
    logic [PEAK_W-1:0]      mag_clamped;
    logic [PROD_W-1:0]      product;

    // finish side
    logic [PEAK_W-1:0]  quo;
    logic [RES_W-1:0]   r_fin;
    logic [RES_W-1:0]   r_lim;
    logic [RES_W-1:0]   r_out;
    logic [RES_W-1:0]   limit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LINF;
            planes_reg <= PLANES_RESET;
            peak_reg   <= PEAK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SCALING_MODE: mode_reg   <= cfg_data[MODE_W-1:0];
                REG_BIT_PLANES:   planes_reg <= cfg_data[PLANES_W-1:0];
                REG_PEAK_VALUE:   peak_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // quantizer full scale 2^(n+1)-1, wraps to all ones for n = 31
    assign full = (PEAK_W'(1) << (6'(planes_reg) + 6'd1)) - PEAK_W'(1);

    // sign, magnitude and level shift of the incoming item
    always_comb
    begin
        value_u   = value;
        neg_in    = value_u[VALUE_WIDTH-1];
        mag_in    = neg_in ? (~value_u + VALUE_WIDTH'(1)) : value_u;
        depth_sat = (depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth;
        case (mode_reg)
            MODE_L1: sh_in = {depth_sat, 1'b0};
            MODE_L2: sh_in = {1'b0, depth_sat};
            default: sh_in = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            neg_reg <= neg_in;
            mag_reg <= mag_in;
            sh_reg  <= sh_in;
        end
    end

    // scaled magnitude, range checks and operand selection
    always_comb
    begin
        s           = mag_reg >> sh_reg;
        s_cw        = CW'(s);
        peak_cw     = CW'(peak_reg);
        mag_cw      = CW'(mag_reg);
        over        = s_cw > peak_cw;
        d_cw        = s_cw - peak_cw;
        big         = over && (d_cw > CW'(PEAK_MAX));
        clamp       = mag_cw > CW'(full);
        s_sat       = (s_cw > CW'(PEAK_MAX)) ? PEAK_MAX : s_cw[PEAK_W-1:0];
        mag_clamped = clamp ? full : mag_cw[PEAK_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            over_reg  <= over;
            big_reg   <= big;
            clamp_reg <= clamp;
            if (cmd_reg == CMD_QUANT)
            begin
                // above the peak only the excess matters, to tell saturation
                op_a_reg <= over ? d_cw[PEAK_W-1:0] : s_cw[PEAK_W-1:0];
                op_b_reg <= full;
                div_reg  <= peak_reg;
            end
            else
            begin
                op_a_reg <= mag_clamped;
                op_b_reg <= peak_reg;
                div_reg  <= full;
            end
        end
    end

    // running peak of scaled quantize magnitudes
    always_comb
    begin
        run_peak_next = run_peak_reg;
        if (cmd.prep && (cmd_reg == CMD_QUANT) && (s_sat > run_peak_reg))
        begin
            run_peak_next = s_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_peak_reg <= '0;
        end
        else
        begin
            run_peak_reg <= run_peak_next;
        end
    end

    // product register
    assign product = PROD_W'(op_a_reg) * PROD_W'(op_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            product_reg <= product;
        end
    end

    // shared divider
    wcq_div u_div
    (
        .clk      (clk),
        .cmd      (cmd.div),
        .dividend (product_reg),
        .divisor  (div_reg),
        .quotient (quo)
    );

    // code or reconstruction, saturation and sign
    always_comb
    begin
        limit = (RES_W'(1) << (VALUE_WIDTH - 1)) - {{(RES_W-1){1'b0}}, ~neg_reg};
        r_fin = '0;
        status_next = ST_OK;
        if (peak_reg == '0)
        begin
            status_next = ST_ZERO;
        end
        else if (cmd_reg == CMD_QUANT)
        begin
            if (over_reg)
            begin
                r_fin = RES_W'(full);
                if (big_reg || (product_reg >= PROD_W'(peak_reg)))
                begin
                    status_next = ST_SAT;
                end
            end
            else
            begin
                r_fin = RES_W'(quo);
            end
        end
        else
        begin
            r_fin = RES_W'(quo) << sh_reg;
            if (clamp_reg)
            begin
                status_next = ST_SAT;
            end
        end
        r_lim = r_fin;
        if (r_fin > limit)
        begin
            r_lim       = limit;
            status_next = ST_SAT;
        end
        r_out       = neg_reg ? (~r_lim + RES_W'(1)) : r_lim;
        result_next = r_out[VALUE_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg    <= result_next;
            status_reg    <= status_next;
            peak_seen_reg <= run_peak_reg;
        end
    end

    assign result    = $signed(result_reg);
    assign status    = status_reg;
    assign peak_seen = peak_seen_reg;

endmodule

// ----- rtl/wcq_ctrl.sv -----
// Controller: sequences load, prepare, multiply, divide and finish for one item
module wcq_ctrl
    import wcq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DINIT = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div.init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div.step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output item flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/wavelet_coef_quantizer.sv -----
// Top level of the wavelet coefficient quantizer
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   input    | in_valid / in_ready    | command, value, depth
//   output   | out_valid / out_ready  | result, peak_seen, status
//   config   | cfg_wr_en              | cfg_index, cfg_data
//
// Each item passes through accept, prepare, multiply, divider load, 32 restoring
// divider steps at one quotient bit each, and finish, where the result is registered;
// finish waits while the output register still holds an untaken result.
// One item is in work at a time: a new item is taken only after the last finishes.
// Reset idles the controller, clears the running peak and returns the
// configuration registers to their defaults.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its finish step waits for that register to be taken.
module wavelet_coef_quantizer
    import wcq_pkg::*;
#(
    parameter int MAX_DEPTH   = 15,
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic [DEPTH_W-1:0]            depth,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] result,
    output logic [PEAK_W-1:0]             peak_seen,
    output logic [STATUS_W-1:0]           status,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [PEAK_W-1:0]             cfg_data
);

    dp_cmd_t cmd;

    // sequencing
    wcq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // arithmetic
    wcq_datapath #(
        .MAX_DEPTH   (MAX_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command),
        .value     (value),
        .depth     (depth),
        .result    (result),
        .peak_seen (peak_seen),
        .status    (status)
    );

endmodule

// ----- rtl/wcq_checker.sv -----
// Port-level checks of the wavelet coefficient quantizer, bound to the top level
module wcq_checker
    import wcq_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [VALUE_WIDTH-1:0] result,
    input logic [PEAK_W-1:0]             peak_seen,
    input logic [STATUS_W-1:0]           status
);

    // a stalled output item holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result) && $stable(status)
            && $stable(peak_seen))
    else $error("output item changed while stalled");

    // a zero peak register gives a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ZERO) |-> (result == '0))
    else $error("zero peak status with nonzero result");

    // an accepted item keeps the block busy for the following cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted again while an item is in work");

endmodule

bind wavelet_coef_quantizer wcq_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_wcq_checker (.*);

// ----- dv/wavelet_coef_quantizer_tb.sv -----
// Self-checking testbench for the wavelet coefficient quantizer top level
module wavelet_coef_quantizer_tb
    import wcq_pkg::*;
();

    // the spare scaling mode code, treated as no scaling
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [31:0]       TOP_BIT    = 32'h8000_0000;
    localparam logic [31:0]       ONE_Q16    = 32'h0001_0000;

    typedef struct packed {
        logic [31:0]         result;
        logic [PEAK_W-1:0]   peak_seen;
        logic [STATUS_W-1:0] status;
    } coef_out_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   command;
    logic signed [31:0]     value;
    logic [DEPTH_W-1:0]     depth;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [31:0]     result;
    logic [PEAK_W-1:0]      peak_seen;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [PEAK_W-1:0]      cfg_data;

    // own copy of the configuration and the running peak
    logic [MODE_W-1:0]      cur_mode;
    logic [PLANES_W-1:0]    cur_planes;
    logic [PEAK_W-1:0]      cur_full_scale;
    logic [PEAK_W-1:0]      track_peak;

    coef_out_t              expected_q[$];
    int                     error_count;

    wavelet_coef_quantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .depth     (depth),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .peak_seen (peak_seen),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // shift that removes the level weight
    function automatic int unsigned level_shift(input logic [DEPTH_W-1:0] dep);
        if (cur_mode == MODE_L1)
            return 2 * 32'(dep);
        if (cur_mode == MODE_L2)
            return 32'(dep);
        return 0;
    endfunction

    // floor(a*b/c), saturated to 64 bits
    function automatic logic [63:0] scaled_ratio(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [63:0] c);
        logic [127:0] prod;
        logic [127:0] quo;
        prod = {64'd0, a} * {64'd0, b};
        quo  = prod / {64'd0, c};
        if (quo[127:64] != 64'd0)
            return '1;
        return quo[63:0];
    endfunction

    // expected result of one item; updates the running peak
    function automatic coef_out_t predict_coef(input logic cmd, input logic [31:0] val,
                                               input logic [DEPTH_W-1:0] dep);
        coef_out_t   exp_out;
        logic        neg;
        logic [31:0] mag32;
        logic [63:0] mag;
        logic [63:0] scaled;
        logic [63:0] full;
        logic [63:0] limit;
        logic [63:0] r;
        int unsigned sh;
        neg     = val[31];
        mag32   = neg ? (~val + 32'd1) : val;
        mag     = {32'd0, mag32};
        sh      = level_shift(dep);
        full    = (64'd1 << (cur_planes + 1)) - 64'd1;
        limit   = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        r       = 64'd0;
        exp_out.status = ST_OK;
        if (cmd == CMD_QUANT)
        begin
            scaled = mag >> sh;
            if (scaled > {32'd0, PEAK_MAX})
                scaled = {32'd0, PEAK_MAX};
            if (scaled[31:0] > track_peak)
                track_peak = scaled[31:0];
            if (cur_full_scale == '0)
                exp_out.status = ST_ZERO;
            else
            begin
                r = scaled_ratio(mag >> sh, full, {32'd0, cur_full_scale});
                if (r > full)
                begin
                    r = full;
                    exp_out.status = ST_SAT;
                end
            end
        end
        else
        begin
            if (cur_full_scale == '0)
                exp_out.status = ST_ZERO;
            else
            begin
                if (mag > full)
                begin
                    mag = full;
                    exp_out.status = ST_SAT;
                end
                r = scaled_ratio(mag, {32'd0, cur_full_scale}, full) << sh;
            end
        end
        if (r > limit)
        begin
            r = limit;
            exp_out.status = ST_SAT;
        end
        exp_out.result    = neg ? (~r[31:0] + 32'd1) : r[31:0];
        exp_out.peak_seen = track_peak;
        return exp_out;
    endfunction

    // send one item and record its expected result
    task automatic send_coef(input logic cmd, input logic [31:0] val,
                             input logic [DEPTH_W-1:0] dep);
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        depth    <= dep;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(predict_coef(cmd, val, dep));
    endtask

    // stop sending and wait until every result is back
    task automatic drain_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PEAK_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SCALING_MODE: cur_mode       = data[MODE_W-1:0];
            REG_BIT_PLANES:   cur_planes     = data[PLANES_W-1:0];
            REG_PEAK_VALUE:   cur_full_scale = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [PLANES_W-1:0] planes,
                              input logic [PEAK_W-1:0] peak);
        write_reg(REG_SCALING_MODE, {30'd0, mode});
        write_reg(REG_BIT_PLANES, {27'd0, planes});
        write_reg(REG_PEAK_VALUE, peak);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // reset configuration: extremes of value and code
    task automatic test_reset_defaults;
        send_coef(CMD_QUANT, 32'd0, 4'd0);
        send_coef(CMD_QUANT, ONE_Q16, 4'd0);
        send_coef(CMD_QUANT, -ONE_Q16, 4'd15);
        send_coef(CMD_QUANT, 32'h7FFF_FFFF, 4'd0);
        send_coef(CMD_QUANT, TOP_BIT, 4'd0);
        send_coef(CMD_DEQUANT, 32'd255, 4'd0);
        send_coef(CMD_DEQUANT, -32'sd256, 4'd7);
        send_coef(CMD_DEQUANT, TOP_BIT, 4'd15);
        drain_results();
    endtask

    // zero peak register on both commands
    task automatic test_zero_peak;
        set_config(MODE_LINF, PLANES_RESET, 32'd0);
        send_coef(CMD_QUANT, 32'd1234567, 4'd2);
        send_coef(CMD_DEQUANT, -32'sd5, 4'd2);
        drain_results();
    endtask

    // deepest shifts, zero and 30 planes, spare mode, unscale overflow
    task automatic test_scaling_modes;
        set_config(MODE_L1, 5'd0, TOP_BIT);
        send_coef(CMD_QUANT, 32'h7FFF_FFFF, 4'd15);
        send_coef(CMD_DEQUANT, 32'd1, 4'd15);
        send_coef(CMD_DEQUANT, 32'hFFFF_FFFF, 4'd15);
        drain_results();
        set_config(MODE_L2, 5'd30, 32'd1);
        send_coef(CMD_QUANT, TOP_BIT, 4'd0);
        send_coef(CMD_QUANT, 32'hFFFF_FFFF, 4'd3);
        send_coef(CMD_DEQUANT, 32'h7FFF_FFFF, 4'd15);
        drain_results();
        set_config(MODE_SPARE, 5'd30, TOP_BIT);
        send_coef(CMD_QUANT, 32'h4000_0000, 4'd9);
        send_coef(CMD_DEQUANT, TOP_BIT, 4'd9);
        send_coef(CMD_DEQUANT, 32'h7FFF_FFFF, 4'd9);
        drain_results();
    endtask

    // random phases, each under its own configuration
    task automatic test_random_phases;
        logic [MODE_W-1:0]   mode;
        logic [PLANES_W-1:0] planes;
        logic [PEAK_W-1:0]   peak;
        logic                cmd;
        logic [31:0]         val;
        logic [63:0]         mag;
        logic [63:0]         full;
        logic [DEPTH_W-1:0]  dep;
        int                  burst_left;
        int                  gap;
        burst_left = 0;
        for (int phase = 0; phase < 10; phase++)
        begin
            mode   = MODE_W'($urandom_range(0, 3));
            planes = PLANES_W'($urandom_range(0, 30));
            case ($urandom_range(0, 9))
                0, 1, 2: peak = (track_peak != 0) ? track_peak : ONE_Q16;
                3:       peak = TOP_BIT;
                4, 5:    peak = $urandom_range(1, 32'hFFFF);
                9:       peak = 32'd0;
                default: peak = $urandom_range(1, TOP_BIT);
            endcase
            if (phase == 0)
                set_config(MODE_LINF, 5'd0, 32'd1);
            else if (phase == 1)
                set_config(MODE_L1, 5'd30, TOP_BIT);
            else
                set_config(mode, planes, peak);
            for (int i = 0; i < 70; i++)
            begin
                // hold-off until the block has emptied
                if (i == 35 && phase % 2 == 0)
                    drain_results();
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
                    if (gap > 0)
                    begin
                        @(negedge clk);
                        in_valid <= 1'b0;
                        repeat (gap - 1) @(negedge clk);
                    end
                    burst_left = $urandom_range(1, 12);
                end
                dep  = DEPTH_W'($urandom_range(0, 15));
                full = (64'd1 << (cur_planes + 1)) - 64'd1;
                cmd  = ($urandom_range(0, 9) < 6) ? CMD_QUANT : CMD_DEQUANT;
                case ($urandom_range(0, 7))
                    0:       mag = {32'd0, $urandom};
                    1:       mag = 64'($urandom_range(0, 16'hFFFF));
                    2:       mag = ($urandom_range(0, 1) == 0) ? 64'h8000_0000 : 64'd0;
                    default:
                        if (cmd == CMD_QUANT)
                            mag = {32'd0, 32'($urandom_range(0, cur_full_scale))}
                                  << level_shift(dep);
                        else if ($urandom_range(0, 5) == 0)
                            mag = full + 64'($urandom_range(0, 3));
                        else
                            mag = 64'($urandom_range(0, full[31:0]));
                endcase
                if (mag > 64'h8000_0000)
                    mag = 64'h8000_0000;
                val = ($urandom_range(0, 1) == 1) ? (32'd0 - mag[31:0]) : mag[31:0];
                send_coef(cmd, val, dep);
                burst_left--;
            end
            drain_results();
        end
    endtask

    // receiver stall pattern, changing character every stretch
    initial
    begin
        int stretch_left;
        int stall_kind;
        int cyc;
        out_ready    = 1'b0;
        stretch_left = 0;
        stall_kind   = 0;
        cyc          = 0;
        forever
        begin
            if (stretch_left == 0)
            begin
                stall_kind   = $urandom_range(0, 3);
                stretch_left = $urandom_range(16, 80);
            end
            @(negedge clk);
            case (stall_kind)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= (cyc % 7 < 3);
            endcase
            stretch_left--;
            cyc++;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        coef_out_t exp_out;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                flag_error($sformatf("unexpected result %h", result));
            else
            begin
                exp_out = expected_q.pop_front();
                if (result !== exp_out.result)
                    flag_error($sformatf("result got %h expected %h",
                                         result, exp_out.result));
                if (peak_seen !== exp_out.peak_seen)
                    flag_error($sformatf("peak_seen got %h expected %h",
                                         peak_seen, exp_out.peak_seen));
                if (status !== exp_out.status)
                    flag_error($sformatf("status got %0d expected %0d",
                                         status, exp_out.status));
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_QUANT;
        value          = '0;
        depth          = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_SCALING_MODE;
        cfg_data       = '0;
        error_count    = 0;
        cur_mode       = MODE_LINF;
        cur_planes     = PLANES_RESET;
        cur_full_scale = ONE_Q16;
        track_peak     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_peak();
        test_scaling_modes();
        test_random_phases();

        drain_results();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
